[src/alvl_pkg.sv]
// ----------------------------------------------------------------------------
// alvl_pkg
// shared types and constants for the low-pass / volume / limiter block
// ----------------------------------------------------------------------------
package alvl_pkg;

  localparam int SAMPLE_IN_W  = 24;
  localparam int SAMPLE_OUT_W = 16;
  localparam int CHAN_W       = 3;
  localparam int ACC_W        = 40;
  localparam int COEF_W       = 17;
  localparam int CFG_IDX_W    = 2;

  // 1.0 in q1.16
  localparam logic [COEF_W-1:0] ONE_Q16 = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_UPD,
    S_OUT
  } state_t;

  // control from the sequencer to the accumulator unit
  typedef struct packed {
    logic capture;   // take ram data and form alpha * d
    logic bypass;    // load the accumulator with the input
    logic in_range;  // channel has an accumulator
  } acc_ctrl_t;

endpackage

[src/audio_lowpass_volume_limiter.sv]
// ----------------------------------------------------------------------------
// audio_lowpass_volume_limiter
// per-channel one-pole low-pass, master volume and 16-bit saturation
// ----------------------------------------------------------------------------
// sequencing: an accepted item passes S_FILT and S_UPD, and out_valid rises when S_OUT
//   loads the output register; no new item is taken before that load, because of the
//   read-modify-write of the accumulator ram (registered read, then alpha multiply,
//   then write back alongside the volume multiply)
// reset: synchronous; accumulators read as zero, bypass on, alpha and volume 1.0
// ----------------------------------------------------------------------------
module audio_lowpass_volume_limiter #(
  parameter int CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [alvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alvl_pkg::COEF_W-1:0]       cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [alvl_pkg::CHAN_W-1:0]       chan_index,
  input  logic signed [alvl_pkg::SAMPLE_IN_W-1:0] sample_in,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [alvl_pkg::CHAN_W-1:0]       chan_out,
  output logic signed [alvl_pkg::SAMPLE_OUT_W-1:0] sample_out,
  output logic                              clipped
);
  import alvl_pkg::*;

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CHAN_LIMIT = 5'(CHANNELS);

  // configuration registers
  logic              filter_bypass;
  logic [COEF_W-1:0] filter_alpha;
  logic [COEF_W-1:0] master_volume;
  logic [COEF_W-1:0] alpha_clamped;
  logic [COEF_W-1:0] volume_clamped;

  // sequencer
  state_t state;
  state_t state_next;
  logic   in_accept;
  logic   capture;
  logic   update;
  logic   out_load;

  // item being worked on
  logic [CHAN_W-1:0]      chan_q;
  logic [SAMPLE_IN_W-1:0] sample_q;
  logic [3:0]             chan_in_ext;
  logic [3:0]             chan_q_ext;
  logic                   in_range;
  logic [ACC_W-1:0]       x;

  // accumulator store
  logic [CHANNELS-1:0] acc_valid;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ACC_W-1:0]    acc_rd;
  logic [ACC_W-1:0]    acc_new;
  logic                acc_we;
  acc_ctrl_t           acc_ctrl;

  logic [SAMPLE_OUT_W-1:0] sat;
  logic                    clip;

  // ---------------------------------------------------------------------------
  // configuration port, values above 1.0 are clamped on use
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bypass <= 1'b1;
      filter_alpha  <= ONE_Q16;
      master_volume <= ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYPASS: filter_bypass <= cfg_data[0];
        REG_ALPHA:  filter_alpha  <= cfg_data;
        REG_VOLUME: master_volume <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign alpha_clamped  = (filter_alpha  > ONE_Q16) ? ONE_Q16 : filter_alpha;
  assign volume_clamped = (master_volume > ONE_Q16) ? ONE_Q16 : master_volume;

  // ---------------------------------------------------------------------------
  // sequencer: idle -> filter multiply -> write back / volume -> output
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_FILT;
      S_FILT: state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    update   = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_FILT: capture  = 1'b1;
      S_UPD:  update   = 1'b1;
      // the output register frees as the waiting item is taken
      S_OUT:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // item capture and channel decode
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      chan_q   <= chan_index;
      sample_q <= sample_in;
    end
  end

  assign chan_in_ext = {1'b0, chan_index};
  assign chan_q_ext  = {1'b0, chan_q};
  assign rd_addr     = chan_in_ext[ADDR_W-1:0];
  assign wr_addr     = chan_q_ext[ADDR_W-1:0];
  assign in_range    = {2'b00, chan_q} < CHAN_LIMIT;

  // sample moved to q8.31
  assign x = {sample_q, 16'h0000};

  // ---------------------------------------------------------------------------
  // accumulator ram; one item in flight so the read never races a write
  // ---------------------------------------------------------------------------
  assign acc_we = update && in_range;

  alvl_ram #(
    .WIDTH (ACC_W),
    .DEPTH (CHANNELS),
    .ADDR_W(ADDR_W)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(wr_addr),
    .wdata(acc_new),
    .re   (in_accept),
    .raddr(rd_addr),
    .rdata(acc_rd)
  );

  // per-entry valid bits stand in for clearing the ram at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else if (acc_we) begin
      acc_valid[wr_addr] <= 1'b1;
    end
  end

  assign acc_ctrl.capture  = capture;
  assign acc_ctrl.bypass   = filter_bypass;
  assign acc_ctrl.in_range = in_range;

  alvl_acc_unit u_acc (
    .clk         (clk),
    .ctrl        (acc_ctrl),
    .acc_rd      (acc_rd),
    .acc_rd_valid(acc_valid[wr_addr]),
    .x           (x),
    .alpha       (alpha_clamped),
    .acc_new     (acc_new)
  );

  // ---------------------------------------------------------------------------
  // volume and limiter
  // ---------------------------------------------------------------------------
  alvl_gain u_gain (
    .clk (clk),
    .en  (update),
    .y   (acc_new),
    .vol (volume_clamped),
    .sat (sat),
    .clip(clip)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      chan_out   <= chan_q;
      sample_out <= signed'(sat);
      clipped    <= clip;
    end
  end

endmodule

[src/alvl_ram.sv]
// ----------------------------------------------------------------------------
// alvl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module alvl_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/alvl_acc_unit.sv]
// ----------------------------------------------------------------------------
// alvl_acc_unit
// one-pole filter update: registered alpha * (x - acc), then add back
// ----------------------------------------------------------------------------
module alvl_acc_unit (
  input  logic                         clk,
  input  alvl_pkg::acc_ctrl_t          ctrl,
  input  logic [alvl_pkg::ACC_W-1:0]   acc_rd,
  input  logic                         acc_rd_valid,
  input  logic [alvl_pkg::ACC_W-1:0]   x,
  input  logic [alvl_pkg::COEF_W-1:0]  alpha,
  output logic [alvl_pkg::ACC_W-1:0]   acc_new
);
  import alvl_pkg::*;

  logic signed [ACC_W-1:0] acc_cur;
  logic signed [ACC_W:0]   diff;
  logic signed [ACC_W-1:0] acc_old;
  logic signed [58:0]      prod;
  logic signed [ACC_W:0]   delta;
  logic signed [ACC_W:0]   sum;

  // entries never written read as zero
  assign acc_cur = acc_rd_valid ? signed'(acc_rd) : '0;
  assign diff    = signed'({x[ACC_W-1], x}) - signed'({acc_cur[ACC_W-1], acc_cur});

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      acc_old <= acc_cur;
      prod    <= diff * signed'({1'b0, alpha});
    end
  end

  // floor shift by 16; |delta| <= |diff| so 41 bits hold it
  assign delta = prod[56:16];
  assign sum   = signed'({acc_old[ACC_W-1], acc_old}) + delta;

  assign acc_new = (ctrl.bypass || !ctrl.in_range) ? x : sum[ACC_W-1:0];

endmodule

[src/alvl_gain.sv]
// ----------------------------------------------------------------------------
// alvl_gain
// master volume multiply, clip detect and saturation to q1.15
// ----------------------------------------------------------------------------
module alvl_gain (
  input  logic                              clk,
  input  logic                              en,
  input  logic [alvl_pkg::ACC_W-1:0]        y,
  input  logic [alvl_pkg::COEF_W-1:0]       vol,
  output logic [alvl_pkg::SAMPLE_OUT_W-1:0] sat,
  output logic                              clip
);
  import alvl_pkg::*;

  localparam logic signed [57:0] P_ONE = 58'sd1 <<< 47;

  logic signed [57:0] p;
  logic               fits;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= signed'(y) * signed'({1'b0, vol});
    end
  end

  assign clip = (p > P_ONE) || (p < -P_ONE);

  // p >>> 32 fits 16 bits when the top bits are all sign copies
  assign fits = (p[57:47] == '0) || (p[57:47] == '1);

  always_comb begin
    if (fits) begin
      sat = p[47:32];
    end else if (p[57]) begin
      sat = 16'h8000;
    end else begin
      sat = 16'h7fff;
    end
  end

endmodule

[src/alvl_checker.sv]
// ----------------------------------------------------------------------------
// alvl_checker
// port-level checks for audio_lowpass_volume_limiter, bound to the top level
// ----------------------------------------------------------------------------
module alvl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         chan_out,
  input logic signed [15:0] sample_out,
  input logic               clipped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out)
      && $stable(chan_out) && $stable(clipped))
    else $error("result changed while stalled");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // a clipped result is always at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> sample_out == 16'sh7fff || sample_out == -16'sh8000)
    else $error("clipped result not saturated");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind audio_lowpass_volume_limiter alvl_checker u_alvl_checker (.*);
